@@ design/fts_pkg.sv @@
package fts_pkg;

  localparam int DUR_W    = 24;
  localparam int RATE_W   = 28;
  localparam int ACC_W    = 25;
  localparam int PERIOD_W = 24;

  localparam logic [RATE_W-1:0]   RATE_NUM     = 28'd256000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000000;
  localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};

  typedef struct packed {
    logic [DUR_W-1:0] delta_us;
    logic             suppressed;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] fps_avg;
    logic [DUR_W-1:0]  frame_time_us;
    logic [DUR_W-1:0]  avg_time_us;
    logic [DUR_W-1:0]  max_time_us;
    logic [DUR_W-1:0]  min_time_us;
    logic              window_restart;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_RATE,
    ST_MEAN,
    ST_FPS,
    ST_AVG,
    ST_DONE
  } state_t;

endpackage

@@ design/fts_ram.sv @@
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/fts_div.sv @@
module fts_div #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial    = {rem, quo[W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign busy     = (cnt != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/frame_time_statistics_top.sv @@
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// in       | in_valid / in_ready  | in_data  (fts_pkg::in_item_t)
// out      | out_valid / out_ready| out_data (fts_pkg::out_item_t)
// cfg      | cfg_wr_en            | cfg_wr_data (restart period, us)
//
// The one shared radix-2 divider is DW = 28+clog2(WINDOW+1) bits wide (35 at WINDOW=64)
// and works in turn on the rate of the new sample, then on both window means.
// A suppressed item skips the rate division. Window sums are kept as running totals.
// Synchronous active-high reset; the sample memory is not cleared.
// in_ready is high only while the sequencer is idle; one result waits in the output
// register while the next item is worked on.
module frame_time_statistics_top #(
  parameter int WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fts_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fts_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [fts_pkg::PERIOD_W-1:0]        cfg_wr_data
);

  localparam int CW    = $clog2(WINDOW + 1);
  localparam int AW    = $clog2(WINDOW);
  localparam int TSW   = fts_pkg::DUR_W + CW;
  localparam int RSW   = fts_pkg::RATE_W + CW;
  localparam int DIV_W = RSW;
  localparam int ENT_W = fts_pkg::RATE_W + fts_pkg::DUR_W;

  fts_pkg::state_t state, state_next;

  logic [fts_pkg::PERIOD_W-1:0] period;
  logic [fts_pkg::DUR_W-1:0]    d;
  logic                         supp;
  logic [fts_pkg::ACC_W-1:0]    accum;
  logic [fts_pkg::DUR_W-1:0]    frame_max;
  logic [fts_pkg::DUR_W-1:0]    frame_min;
  logic                         restart;
  logic [CW-1:0]                fill;
  logic [AW-1:0]                slot;
  logic [TSW-1:0]               time_sum;
  logic [RSW-1:0]               rate_sum;
  logic [fts_pkg::DUR_W-1:0]    old_d;
  logic [fts_pkg::RATE_W-1:0]   old_rate;
  logic [fts_pkg::RATE_W-1:0]   fps;
  logic [fts_pkg::DUR_W-1:0]    avg;

  logic                         in_fire;
  logic                         out_load;
  logic [fts_pkg::ACC_W:0]      acc_add;
  logic [fts_pkg::ACC_W-1:0]    acc_sat;
  logic                         full;

  logic                         ram_we;
  logic [ENT_W-1:0]             ram_rdata;

  logic                         div_start;
  logic [DIV_W-1:0]             div_dividend;
  logic [DIV_W-1:0]             div_divisor;
  logic                         div_busy;
  logic                         div_done;
  logic [DIV_W-1:0]             div_quo;

  assign in_ready = (state == fts_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (fill == CW'(WINDOW));
  assign acc_add  = {1'b0, accum} + (fts_pkg::ACC_W + 1)'(d);
  assign acc_sat  = acc_add[fts_pkg::ACC_W] ? fts_pkg::ACC_MAX : acc_add[fts_pkg::ACC_W-1:0];
  assign out_load = (state == fts_pkg::ST_DONE) && (!out_valid || out_ready);
  assign ram_we   = (state == fts_pkg::ST_RATE) && div_done;

  fts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({div_quo[fts_pkg::RATE_W-1:0], d}),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  fts_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = DIV_W'(fts_pkg::RATE_NUM);
    div_divisor  = DIV_W'(d);
    case (state)
      fts_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = fts_pkg::ST_ACC;
        end
      end
      fts_pkg::ST_ACC: begin
        if (supp) begin
          state_next = fts_pkg::ST_MEAN;
        end else begin
          div_start  = 1'b1;
          state_next = fts_pkg::ST_RATE;
        end
      end
      fts_pkg::ST_RATE: begin
        if (div_done) begin
          state_next = fts_pkg::ST_MEAN;
        end
      end
      fts_pkg::ST_MEAN: begin
        div_dividend = DIV_W'(rate_sum);
        div_divisor  = DIV_W'(fill);
        if (fill == '0) begin
          state_next = fts_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = fts_pkg::ST_FPS;
        end
      end
      fts_pkg::ST_FPS: begin
        div_dividend = DIV_W'(time_sum);
        div_divisor  = DIV_W'(fill);
        if (div_done) begin
          div_start  = 1'b1;
          state_next = fts_pkg::ST_AVG;
        end
      end
      fts_pkg::ST_AVG: begin
        if (div_done) begin
          state_next = fts_pkg::ST_DONE;
        end
      end
      fts_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = fts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= fts_pkg::PERIOD_RESET;
      accum     <= '0;
      frame_max <= '0;
      frame_min <= '1;
      fill      <= '0;
      slot      <= '0;
      time_sum  <= '0;
      rate_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      if (state == fts_pkg::ST_ACC) begin
        if ({1'b0, acc_sat} >= (fts_pkg::ACC_W + 1)'(period)) begin
          accum     <= '0;
          frame_max <= d;
          frame_min <= d;
        end else begin
          accum <= acc_sat;
          if (d > frame_max) begin
            frame_max <= d;
          end
          if (d < frame_min) begin
            frame_min <= d;
          end
        end
      end
      if (ram_we) begin
        time_sum <= time_sum + TSW'(d) - TSW'(old_d);
        rate_sum <= rate_sum + RSW'(div_quo[fts_pkg::RATE_W-1:0]) - RSW'(old_rate);
        slot     <= (slot == AW'(WINDOW - 1)) ? '0 : slot + AW'(1);
        if (!full) begin
          fill <= fill + CW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d    <= (in_data.delta_us == '0) ? (fts_pkg::DUR_W)'(1) : in_data.delta_us;
      supp <= in_data.suppressed;
    end
    if (state == fts_pkg::ST_ACC) begin
      restart  <= ({1'b0, acc_sat} >= (fts_pkg::ACC_W + 1)'(period));
      old_d    <= full ? ram_rdata[fts_pkg::DUR_W-1:0] : '0;
      old_rate <= full ? ram_rdata[ENT_W-1:fts_pkg::DUR_W] : '0;
    end
    if (state == fts_pkg::ST_MEAN && fill == '0) begin
      fps <= '0;
      avg <= '0;
    end
    if (state == fts_pkg::ST_FPS && div_done) begin
      fps <= div_quo[fts_pkg::RATE_W-1:0];
    end
    if (state == fts_pkg::ST_AVG && div_done) begin
      avg <= div_quo[fts_pkg::DUR_W-1:0];
    end
    if (out_load) begin
      out_data.fps_avg        <= fps;
      out_data.frame_time_us  <= d;
      out_data.avg_time_us    <= avg;
      out_data.max_time_us    <= frame_max;
      out_data.min_time_us    <= frame_min;
      out_data.window_restart <= restart;
    end
  end

  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (time_sum == '0 && rate_sum == '0))
    else $error("window sums nonzero with empty window");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW))
    else $error("fill count beyond window");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (frame_max != '0) |-> (frame_min <= frame_max))
    else $error("running minimum above maximum");

endmodule
